// ===== design/cllm_pkg.sv =====
// cllm_pkg: shared sizes, codes, types and helpers for the cursor linked list manager
// no dependencies; imported by cllm_store and cursor_linked_list_manager
`timescale 1ns / 1ps

package cllm_pkg;

    // store geometry
    localparam int CELL_COUNT = 16;
    localparam int CELL_AW    = $clog2(CELL_COUNT);
    localparam int PTR_W      = $clog2(CELL_COUNT + 1);
    localparam int N_W        = $clog2(2 * CELL_COUNT + 1);

    // field widths
    localparam int OP_W      = 3;
    localparam int VALUE_W   = 32;
    localparam int STATUS_W  = 3;
    localparam int REMOVED_W = 5;

    localparam int S_TDATA_W = ((OP_W + VALUE_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((STATUS_W + VALUE_W + REMOVED_W + 7) / 8) * 8;

    typedef logic [PTR_W-1:0]          t_ptr;
    typedef logic signed [VALUE_W-1:0] t_value;

    localparam t_ptr NIL_PTR = PTR_W'(CELL_COUNT);

    // operation codes
    localparam logic [OP_W-1:0] OP_INS_HEAD   = 3'd0;
    localparam logic [OP_W-1:0] OP_INS_TAIL   = 3'd1;
    localparam logic [OP_W-1:0] OP_INS_SORTED = 3'd2;
    localparam logic [OP_W-1:0] OP_DEL_FIRST  = 3'd3;
    localparam logic [OP_W-1:0] OP_DEL_ALL    = 3'd4;
    localparam logic [OP_W-1:0] OP_READ_ALL   = 3'd5;

    // result status codes
    localparam logic [STATUS_W-1:0] STS_DONE     = 3'd0;
    localparam logic [STATUS_W-1:0] STS_NO_FREE  = 3'd1;
    localparam logic [STATUS_W-1:0] STS_NO_MATCH = 3'd2;
    localparam logic [STATUS_W-1:0] STS_ELEMENT  = 3'd3;
    localparam logic [STATUS_W-1:0] STS_EMPTY    = 3'd4;

    // write request into the cell store
    typedef struct packed {
        logic   link_en;
        t_ptr   link_addr;
        t_ptr   link_data;
        logic   value_en;
        t_ptr   value_addr;
        t_value value_data;
    } t_store_wr;

    function automatic logic is_cell(input t_ptr p);
        return p < NIL_PTR;
    endfunction

endpackage

// ===== design/cllm_store.sv =====
// cllm_store: cell value words and link words with one read port and one write request
// depends on cllm_pkg
`timescale 1ns / 1ps

module cllm_store (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cllm_pkg::t_ptr    i_rd_addr,
    output cllm_pkg::t_value  o_rd_value,
    output cllm_pkg::t_ptr    o_rd_link,
    input  cllm_pkg::t_store_wr i_wr
);
    import cllm_pkg::*;

    t_value r_value [CELL_COUNT];
    t_ptr   r_link  [CELL_COUNT];

    // value words hold nothing meaningful until written
    always_ff @(posedge i_clk) begin
        if (i_wr.value_en) begin
            r_value[i_wr.value_addr[CELL_AW-1:0]] <= i_wr.value_data;
        end
    end

    // links reset to the initial free chain, cell i to i+1, last to nil
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CELL_COUNT; i++) begin
                r_link[i] <= PTR_W'(i + 1);
            end
        end else if (i_wr.link_en) begin
            r_link[i_wr.link_addr[CELL_AW-1:0]] <= i_wr.link_data;
        end
    end

    assign o_rd_value = r_value[i_rd_addr[CELL_AW-1:0]];
    assign o_rd_link  = r_link[i_rd_addr[CELL_AW-1:0]];

endmodule

// ===== design/cursor_linked_list_manager.sv =====
// cursor_linked_list_manager: top level, request sequencer, shared compare unit, result register
// depends on cllm_pkg and cllm_store
`timescale 1ns / 1ps

// A sorted-or-unsorted singly linked list of signed 32-bit values kept in a
// store of CELL_COUNT cells (16), with unused cells chained into a free list
// through the same link words. One request is taken at a time: s_axis_tready is
// high only while the sequencer is idle. Every request gives at least one
// result and the final one has m_axis_tlast set; a read-all request gives one
// result per element. The list walk visits one cell per cycle through the single
// store read port and the shared compare unit: insert at head needs no walk,
// insert at tail, sorted insert and delete-first walk up to CELL_COUNT cells,
// delete-all unlinks a removed cell and frees it in a second step, and read-all
// gives one result per cycle while the output side keeps up. A result waiting in
// the output register does not stall the walk; only the load of the next result
// waits.
// Freed cells go back to the head of the free list; a new cell is always taken
// from the head of the free list.
module cursor_linked_list_manager (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // request: op [2:0], value [34:3], zero fill [39:35]
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [cllm_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // result: status [2:0], value_out [34:3], removed [39:35]
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [cllm_pkg::M_TDATA_W-1:0] m_axis_tdata,
    output logic                           m_axis_tlast
);
    import cllm_pkg::*;

    // sequencer states
    localparam logic [3:0] ST_IDLE       = 4'd0;
    localparam logic [3:0] ST_WALK       = 4'd1;
    localparam logic [3:0] ST_INS        = 4'd2;
    localparam logic [3:0] ST_LINK       = 4'd3;
    localparam logic [3:0] ST_DEL_UNLINK = 4'd4;
    localparam logic [3:0] ST_DEL_FREE   = 4'd5;
    localparam logic [3:0] ST_DALL       = 4'd6;
    localparam logic [3:0] ST_DALL_FREE  = 4'd7;
    localparam logic [3:0] ST_READ       = 4'd8;
    localparam logic [3:0] ST_EMIT       = 4'd9;

    logic [3:0]           r_state, n_state;
    logic [OP_W-1:0]      r_op, n_op;
    t_value               r_val, n_val;
    t_ptr                 r_prev, n_prev;
    t_ptr                 r_cur, n_cur;
    t_ptr                 r_idx, n_idx;
    t_ptr                 r_nxt, n_nxt;
    logic [N_W-1:0]       r_n, n_n;
    logic [REMOVED_W-1:0] r_count, n_count;
    t_ptr                 r_list_head, n_list_head;
    t_ptr                 r_free_head, n_free_head;
    logic [STATUS_W-1:0]  r_res_status, n_res_status;
    logic [REMOVED_W-1:0] r_res_removed, n_res_removed;

    // output register
    logic                 r_m_valid;
    logic [STATUS_W-1:0]  r_m_status, n_m_status;
    t_value               r_m_value, n_m_value;
    logic [REMOVED_W-1:0] r_m_removed, n_m_removed;
    logic                 r_m_last, n_m_last;
    logic                 load_out;
    logic                 can_load;

    // store access
    t_ptr      rd_addr;
    t_value    rd_value;
    t_ptr      rd_link;
    t_store_wr wr;

    // shared compare unit, always against the request value
    logic cmp_eq;
    logic cmp_lt;

    logic [OP_W-1:0] in_op;
    t_value          in_value;
    logic            in_accept;
    logic            walk_cell;
    logic            walk_bound;
    logic            walk_go;
    logic            read_last;

    assign in_op     = s_axis_tdata[OP_W-1:0];
    assign in_value  = s_axis_tdata[OP_W +: VALUE_W];
    assign in_accept = s_axis_tvalid && s_axis_tready;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign can_load      = !r_m_valid || m_axis_tready;

    assign rd_addr = (r_state == ST_INS) ? r_free_head : r_cur;

    cllm_store u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_addr  (rd_addr),
        .o_rd_value (rd_value),
        .o_rd_link  (rd_link),
        .i_wr       (wr)
    );

    assign cmp_eq = (rd_value == r_val);
    assign cmp_lt = (rd_value < r_val);

    assign walk_cell  = is_cell(r_cur);
    assign walk_bound = r_n < N_W'(CELL_COUNT);
    assign read_last  = !is_cell(rd_link) || (r_n == N_W'(CELL_COUNT - 1));

    always_comb begin
        // walk condition differs per op: tail runs to the end, sorted stops at
        // the first element not smaller, delete-first stops at a match
        case (r_op)
            OP_INS_TAIL:   walk_go = walk_cell && walk_bound;
            OP_INS_SORTED: walk_go = walk_cell && walk_bound && cmp_lt;
            default:       walk_go = walk_cell && walk_bound && !cmp_eq;
        endcase
    end

    always_comb begin
        n_state       = r_state;
        n_op          = r_op;
        n_val         = r_val;
        n_prev        = r_prev;
        n_cur         = r_cur;
        n_idx         = r_idx;
        n_nxt         = r_nxt;
        n_n           = r_n;
        n_count       = r_count;
        n_list_head   = r_list_head;
        n_free_head   = r_free_head;
        n_res_status  = r_res_status;
        n_res_removed = r_res_removed;
        wr            = '0;
        load_out      = 1'b0;
        n_m_status    = r_m_status;
        n_m_value     = r_m_value;
        n_m_removed   = r_m_removed;
        n_m_last      = r_m_last;

        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_op          = in_op;
                    n_val         = in_value;
                    n_prev        = NIL_PTR;
                    n_cur         = r_list_head;
                    n_n           = '0;
                    n_count       = '0;
                    n_res_removed = '0;
                    case (in_op) inside
                        OP_INS_HEAD: n_state = ST_INS;
                        OP_INS_TAIL, OP_INS_SORTED, OP_DEL_FIRST: n_state = ST_WALK;
                        OP_DEL_ALL: n_state = ST_DALL;
                        OP_READ_ALL: begin
                            if (is_cell(r_list_head)) begin
                                n_state = ST_READ;
                            end else begin
                                n_res_status = STS_EMPTY;
                                n_state      = ST_EMIT;
                            end
                        end
                        default: begin
                            // unknown op: plain done
                            n_res_status = STS_DONE;
                            n_state      = ST_EMIT;
                        end
                    endcase
                end
            end

            ST_WALK: begin
                if (walk_go) begin
                    n_prev = r_cur;
                    n_cur  = rd_link;
                    n_n    = r_n + N_W'(1);
                end else if (r_op == OP_DEL_FIRST) begin
                    if (!walk_cell || !walk_bound) begin
                        n_res_status = STS_NO_MATCH;
                        n_state      = ST_EMIT;
                    end else begin
                        n_state = ST_DEL_UNLINK;
                    end
                end else begin
                    n_state = ST_INS;
                end
            end

            ST_INS: begin
                // take the cell at the head of the free list
                if (!is_cell(r_free_head)) begin
                    n_res_status = STS_NO_FREE;
                    n_state      = ST_EMIT;
                end else begin
                    wr.value_en   = 1'b1;
                    wr.value_addr = r_free_head;
                    wr.value_data = r_val;
                    wr.link_en    = 1'b1;
                    wr.link_addr  = r_free_head;
                    wr.link_data  = (r_op == OP_INS_TAIL) ? NIL_PTR : r_cur;
                    n_idx         = r_free_head;
                    n_free_head   = rd_link;
                    n_state       = ST_LINK;
                end
            end

            ST_LINK: begin
                if (is_cell(r_prev)) begin
                    wr.link_en   = 1'b1;
                    wr.link_addr = r_prev;
                    wr.link_data = r_idx;
                end else begin
                    n_list_head = r_idx;
                end
                n_res_status = STS_DONE;
                n_state      = ST_EMIT;
            end

            ST_DEL_UNLINK: begin
                if (is_cell(r_prev)) begin
                    wr.link_en   = 1'b1;
                    wr.link_addr = r_prev;
                    wr.link_data = rd_link;
                end else begin
                    n_list_head = rd_link;
                end
                n_state = ST_DEL_FREE;
            end

            ST_DEL_FREE: begin
                wr.link_en    = 1'b1;
                wr.link_addr  = r_cur;
                wr.link_data  = r_free_head;
                n_free_head   = r_cur;
                n_res_status  = STS_DONE;
                n_res_removed = REMOVED_W'(1);
                n_state       = ST_EMIT;
            end

            ST_DALL: begin
                if (r_n >= N_W'(2 * CELL_COUNT) || !walk_cell) begin
                    n_res_status  = (r_count != '0) ? STS_DONE : STS_NO_MATCH;
                    n_res_removed = r_count;
                    n_state       = ST_EMIT;
                end else if (cmp_eq) begin
                    // unlink now, free the cell next cycle
                    if (is_cell(r_prev)) begin
                        wr.link_en   = 1'b1;
                        wr.link_addr = r_prev;
                        wr.link_data = rd_link;
                    end else begin
                        n_list_head = rd_link;
                    end
                    n_nxt   = rd_link;
                    n_state = ST_DALL_FREE;
                end else begin
                    n_prev = r_cur;
                    n_cur  = rd_link;
                    n_n    = r_n + N_W'(1);
                end
            end

            ST_DALL_FREE: begin
                wr.link_en   = 1'b1;
                wr.link_addr = r_cur;
                wr.link_data = r_free_head;
                n_free_head  = r_cur;
                n_cur        = r_nxt;
                n_count      = r_count + REMOVED_W'(1);
                n_n          = r_n + N_W'(1);
                n_state      = ST_DALL;
            end

            ST_READ: begin
                if (can_load) begin
                    load_out    = 1'b1;
                    n_m_status  = STS_ELEMENT;
                    n_m_value   = rd_value;
                    n_m_removed = '0;
                    n_m_last    = read_last;
                    n_cur       = rd_link;
                    n_n         = r_n + N_W'(1);
                    if (read_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end

            ST_EMIT: begin
                if (can_load) begin
                    load_out    = 1'b1;
                    n_m_status  = r_res_status;
                    n_m_value   = '0;
                    n_m_removed = r_res_removed;
                    n_m_last    = 1'b1;
                    n_state     = ST_IDLE;
                end
            end

            default: n_state = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_list_head <= NIL_PTR;
            r_free_head <= '0;
            r_m_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_list_head <= n_list_head;
            r_free_head <= n_free_head;
            if (load_out) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // working and payload registers
    always_ff @(posedge i_clk) begin
        r_op          <= n_op;
        r_val         <= n_val;
        r_prev        <= n_prev;
        r_cur         <= n_cur;
        r_idx         <= n_idx;
        r_nxt         <= n_nxt;
        r_n           <= n_n;
        r_count       <= n_count;
        r_res_status  <= n_res_status;
        r_res_removed <= n_res_removed;
        r_m_status    <= n_m_status;
        r_m_value     <= n_m_value;
        r_m_removed   <= n_m_removed;
        r_m_last      <= n_m_last;
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tlast  = r_m_last;
    assign m_axis_tdata  = M_TDATA_W'({r_m_removed, r_m_value, r_m_status});

`ifndef NO_ASSERTIONS
    // a taken request always moves the sequencer out of idle in the next cycle
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state != ST_IDLE))
        else $error("request accepted but sequencer stayed idle");

    // the final element of a read ends the request
    a_read_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ && load_out && n_m_last) |=> (r_state == ST_IDLE))
        else $error("read did not finish after its last element");

    // a cell is never at the head of both the list and the free list
    a_heads_disjoint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(is_cell(r_list_head) && (r_list_head == r_free_head)))
        else $error("list head and free head point at the same cell");

    // the walk counter stays within its bound
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> (r_n <= N_W'(2 * CELL_COUNT)))
        else $error("walk counter beyond its bound");

    // a result is only loaded when the output register is free or draining
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && !m_axis_tready) |=> !$rose(r_m_valid) && $stable(m_axis_tdata))
        else $error("pending result overwritten");
`endif

endmodule
